[rtl/u8stc_pkg.sv]
// ----------------------------------------------------------------------------
// u8stc_pkg
// shared types, constants and the code point screen for the utf-8 text checker
// ----------------------------------------------------------------------------
package u8stc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;

    // lead byte masks and patterns
    localparam logic [ByteW-1:0] MASK_LEAD2 = 8'he0;
    localparam logic [ByteW-1:0] MASK_LEAD3 = 8'hf0;
    localparam logic [ByteW-1:0] MASK_LEAD4 = 8'hf8;
    localparam logic [ByteW-1:0] PAT_LEAD2  = 8'hc0;
    localparam logic [ByteW-1:0] PAT_LEAD3  = 8'he0;
    localparam logic [ByteW-1:0] PAT_LEAD4  = 8'hf0;
    localparam logic [ByteW-1:0] MASK_CONT  = 8'hc0;
    localparam logic [ByteW-1:0] PAT_CONT   = 8'h80;

    // sequence widths in bytes
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_W1   = 3'd1;
    localparam logic [2:0] SEQ_W2   = 3'd2;
    localparam logic [2:0] SEQ_W3   = 3'd3;
    localparam logic [2:0] SEQ_W4   = 3'd4;

    // code point limits
    localparam logic [CpW-1:0] CP_MIN2      = 21'h000080;
    localparam logic [CpW-1:0] CP_MIN3      = 21'h000800;
    localparam logic [CpW-1:0] CP_MIN4      = 21'h010000;
    localparam logic [CpW-1:0] CP_MAX       = 21'h10ffff;
    localparam logic [CpW-1:0] CP_SURR_LO   = 21'h00d800;
    localparam logic [CpW-1:0] CP_SURR_HI   = 21'h00dfff;
    localparam logic [CpW-1:0] CP_C0_END    = 21'h000020;
    localparam logic [CpW-1:0] CP_DEL       = 21'h00007f;
    localparam logic [CpW-1:0] CP_C1_HI     = 21'h00009f;
    localparam logic [CpW-1:0] CP_BIDI_O_LO = 21'h00202a;
    localparam logic [CpW-1:0] CP_BIDI_O_HI = 21'h00202e;
    localparam logic [CpW-1:0] CP_BIDI_I_LO = 21'h002066;
    localparam logic [CpW-1:0] CP_BIDI_I_HI = 21'h002069;

    typedef struct packed {
        logic [1:0]     pend;
        logic [2:0]     width;
        logic [CpW-1:0] acc;
        logic           fault;
        logic           any;
    } u8stc_state_t;

    function automatic logic cp_forbidden(input logic [CpW-1:0] cp, input logic [2:0] w);
        logic bad;
        bad = 1'b0;
        if (w == SEQ_W2 && cp < CP_MIN2) bad = 1'b1;
        if (w == SEQ_W3 && cp < CP_MIN3) bad = 1'b1;
        if (w == SEQ_W4 && cp < CP_MIN4) bad = 1'b1;
        if (cp > CP_MAX) bad = 1'b1;
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) bad = 1'b1;
        if (cp < CP_C0_END) bad = 1'b1;
        if (cp >= CP_DEL && cp <= CP_C1_HI) bad = 1'b1;
        if (cp >= CP_BIDI_O_LO && cp <= CP_BIDI_O_HI) bad = 1'b1;
        if (cp >= CP_BIDI_I_LO && cp <= CP_BIDI_I_HI) bad = 1'b1;
        return bad;
    endfunction

endpackage

[rtl/u8stc_if.sv]
// ----------------------------------------------------------------------------
// u8stc channel interfaces
// valid/ready channels for text bytes in and verdicts out
// ----------------------------------------------------------------------------
interface u8stc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_text, output ready);
endinterface

interface u8stc_verdict_if;
    logic valid;
    logic ready;
    logic text_ok;

    modport source (output valid, output text_ok, input ready);
    modport sink   (input valid, input text_ok, output ready);
endinterface

[rtl/u8stc_step.sv]
// ----------------------------------------------------------------------------
// u8stc_step
// decodes one byte against the running utf-8 state and gives the next state
// ----------------------------------------------------------------------------
module u8stc_step (
    input  u8stc_pkg::u8stc_state_t cur,
    input  logic [7:0]              data_byte,
    input  logic                    has_byte,
    output u8stc_pkg::u8stc_state_t nxt
);
    import u8stc_pkg::*;

    logic [CpW-1:0] acc_shift;
    logic [1:0]     pend_dec;

    assign acc_shift = {cur.acc[CpW-7:0], data_byte[5:0]};
    assign pend_dec  = cur.pend - 2'd1;

    always_comb
    begin
        nxt = cur;
        if (has_byte)
        begin
            nxt.any = 1'b1;
            if (!cur.fault)
            begin
                if (cur.pend == 2'd0)
                begin
                    priority if (!data_byte[7])
                    begin
                        if (cp_forbidden({13'd0, data_byte}, SEQ_W1))
                            nxt.fault = 1'b1;
                    end
                    else if ((data_byte & MASK_LEAD2) == PAT_LEAD2)
                    begin
                        nxt.acc   = {16'd0, data_byte[4:0]};
                        nxt.width = SEQ_W2;
                        nxt.pend  = 2'd1;
                    end
                    else if ((data_byte & MASK_LEAD3) == PAT_LEAD3)
                    begin
                        nxt.acc   = {17'd0, data_byte[3:0]};
                        nxt.width = SEQ_W3;
                        nxt.pend  = 2'd2;
                    end
                    else if ((data_byte & MASK_LEAD4) == PAT_LEAD4)
                    begin
                        nxt.acc   = {18'd0, data_byte[2:0]};
                        nxt.width = SEQ_W4;
                        nxt.pend  = 2'd3;
                    end
                    else
                    begin
                        nxt.fault = 1'b1;
                    end
                end
                else if ((data_byte & MASK_CONT) != PAT_CONT)
                begin
                    nxt.fault = 1'b1;
                end
                else
                begin
                    nxt.pend = pend_dec;
                    if (pend_dec == 2'd0)
                    begin
                        // sequence complete: screen the whole code point
                        if (cp_forbidden(acc_shift, cur.width))
                            nxt.fault = 1'b1;
                        nxt.acc   = '0;
                        nxt.width = SEQ_NONE;
                    end
                    else
                    begin
                        nxt.acc = acc_shift;
                    end
                end
            end
        end
    end

endmodule

[rtl/utf8_safe_text_checker.sv]
// ----------------------------------------------------------------------------
// utf8_safe_text_checker
// streaming check of one text for well-formed, control-free utf-8
// ----------------------------------------------------------------------------
// Takes one byte beat per clock and returns one verdict beat for each beat
// marked end_of_text: text_ok is 1 when the text held at least one byte, was
// well-formed utf-8 and carried no control or bidi override/isolate code
// point. A beat is registered on entry, decoded in the following cycle and the
// verdict lands in the output register. Throughput is one beat per clock; the
// input side stalls only while a closing beat waits for the output register
// to be emptied by the downstream side.
module utf8_safe_text_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    u8stc_byte_if.sink             text_bytes,
    u8stc_verdict_if.source        verdict
);
    import u8stc_pkg::*;

    logic         in_vld_reg;
    logic [7:0]   byte_reg;
    logic         has_reg;
    logic         eot_reg;

    u8stc_state_t st_reg;
    u8stc_state_t st_step;
    u8stc_state_t st_next;

    logic         out_vld_reg;
    logic         ok_reg;
    logic         ok_next;

    logic         out_free;
    logic         advance;
    logic         in_take;

    assign out_free = !out_vld_reg || verdict.ready;
    // a closing beat needs the output slot, others always move on
    assign advance  = in_vld_reg && (!eot_reg || out_free);
    assign text_bytes.ready = !in_vld_reg || advance;
    assign in_take  = text_bytes.valid && text_bytes.ready;

    u8stc_step u_step (
        .cur       (st_reg),
        .data_byte (byte_reg),
        .has_byte  (has_reg),
        .nxt       (st_step)
    );

    assign ok_next = st_step.any && !st_step.fault && (st_step.pend == 2'd0);
    assign st_next = eot_reg ? '0 : st_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= '0;
        end
        else
        begin
            if (text_bytes.ready)
                in_vld_reg <= text_bytes.valid;
            if (advance)
                st_reg <= st_next;
            if (advance && eot_reg)
                out_vld_reg <= 1'b1;
            else if (verdict.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= text_bytes.data_byte;
            has_reg  <= text_bytes.has_byte;
            eot_reg  <= text_bytes.end_of_text;
        end
        if (advance && eot_reg)
            ok_reg <= ok_next;
    end

    assign verdict.valid   = out_vld_reg;
    assign verdict.text_ok = ok_reg;

endmodule

[rtl/u8stc_chk.sv]
// ----------------------------------------------------------------------------
// u8stc_chk
// port-level checks on the utf-8 text checker, bound to the top level
// ----------------------------------------------------------------------------
module u8stc_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic text_ok
);

    // a stalled verdict beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_ok))
        else $error("verdict beat changed while stalled");

    // with nothing waiting at the output the input never stalls
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // no verdict straight out of reset
    a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("verdict beat right after reset");

endmodule

bind utf8_safe_text_checker u8stc_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_bytes.valid),
    .in_ready  (text_bytes.ready),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .text_ok   (verdict.text_ok)
);

[dv/utf8_safe_text_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_safe_text_checker_tb
// self-checking bench for the streaming utf-8 text checker: a queue-fed driver
// sends byte beats, a predictor tracks the decode state per text and a monitor
// compares every verdict beat in order, under several idle and stall mixes
// ----------------------------------------------------------------------------
module utf8_safe_text_checker_tb;
    import u8stc_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_text;
    } text_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    u8stc_byte_if    bytes_if ();
    u8stc_verdict_if verdict_if ();

    utf8_safe_text_checker u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_bytes (bytes_if.sink),
        .verdict    (verdict_if.source)
    );

    always #1 clk = ~clk;

    text_beat_t beat_q[$];
    logic       verdict_q[$];
    logic [7:0] text_buf[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_cnt  = 0;
    int beats_taken   = 0;
    int texts_closed  = 0;
    int verdicts_seen = 0;
    int verdicts_ok   = 0;

    // decode state of the text in flight
    logic [1:0]     pend_cnt;
    logic [2:0]     seq_len;
    logic [CpW-1:0] cp_acc;
    logic           bad_seen;
    logic           got_byte;

    function automatic logic in_span(input logic [CpW-1:0] cp, input logic [CpW-1:0] lo,
                                     input logic [CpW-1:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic cp_rejected(input logic [CpW-1:0] cp, input logic [2:0] len);
        logic [CpW-1:0] floor_cp;
        case (len)
            SEQ_W2:  floor_cp = CP_MIN2;
            SEQ_W3:  floor_cp = CP_MIN3;
            SEQ_W4:  floor_cp = CP_MIN4;
            default: floor_cp = '0;
        endcase
        return (cp < floor_cp) || (cp > CP_MAX) || (cp < CP_C0_END)
            || in_span(cp, CP_SURR_LO, CP_SURR_HI) || in_span(cp, CP_DEL, CP_C1_HI)
            || in_span(cp, CP_BIDI_O_LO, CP_BIDI_O_HI)
            || in_span(cp, CP_BIDI_I_LO, CP_BIDI_I_HI);
    endfunction

    function automatic void clear_text_state();
        pend_cnt = 2'd0;
        seq_len  = SEQ_NONE;
        cp_acc   = '0;
        bad_seen = 1'b0;
        got_byte = 1'b0;
    endfunction

    function automatic void predict_beat(input text_beat_t bt);
        logic [7:0] b;
        b = bt.data_byte;
        if (bt.has_byte)
        begin
            got_byte = 1'b1;
            // once a fault is seen the rest of the text is ignored
            if (!bad_seen)
            begin
                if (pend_cnt == 2'd0)
                begin
                    if (b[7] == 1'b0)
                    begin
                        if (cp_rejected({13'd0, b}, SEQ_W1))
                            bad_seen = 1'b1;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        cp_acc   = {16'd0, b[4:0]};
                        seq_len  = SEQ_W2;
                        pend_cnt = 2'd1;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        cp_acc   = {17'd0, b[3:0]};
                        seq_len  = SEQ_W3;
                        pend_cnt = 2'd2;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        cp_acc   = {18'd0, b[2:0]};
                        seq_len  = SEQ_W4;
                        pend_cnt = 2'd3;
                    end
                    else
                    begin
                        bad_seen = 1'b1;
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    bad_seen = 1'b1;
                end
                else
                begin
                    cp_acc   = {cp_acc[CpW-7:0], b[5:0]};
                    pend_cnt = pend_cnt - 2'd1;
                    if (pend_cnt == 2'd0)
                    begin
                        if (cp_rejected(cp_acc, seq_len))
                            bad_seen = 1'b1;
                        cp_acc  = '0;
                        seq_len = SEQ_NONE;
                    end
                end
            end
        end
        if (bt.end_of_text)
        begin
            verdict_q.insert(verdict_q.size(), got_byte && !bad_seen && (pend_cnt == 2'd0));
            texts_closed++;
            clear_text_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        text_beat_t nxt;
        if (rst_n)
        begin
            if (bytes_if.valid && bytes_if.ready)
            begin
                predict_beat({bytes_if.data_byte, bytes_if.has_byte, bytes_if.end_of_text});
                beats_taken++;
            end
            if (!bytes_if.valid || bytes_if.ready)
            begin
                if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = beat_q.pop_front();
                    bytes_if.valid       <= 1'b1;
                    bytes_if.data_byte   <= nxt.data_byte;
                    bytes_if.has_byte    <= nxt.has_byte;
                    bytes_if.end_of_text <= nxt.end_of_text;
                end
                else
                begin
                    bytes_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // verdict monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (verdict_if.valid && verdict_if.ready)
            begin
                verdicts_seen++;
                if (verdict_if.text_ok === 1'b1)
                    verdicts_ok++;
                if (verdict_q.size() == 0)
                begin
                    $error("verdict beat with no text closed: text_ok=%b", verdict_if.text_ok);
                    mismatch_cnt++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (verdict_if.text_ok !== want)
                    begin
                        $error("text_ok mismatch: expected %b, got %b", want,
                               verdict_if.text_ok);
                        mismatch_cnt++;
                    end
                end
            end
            verdict_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] b, input logic has, input logic eot);
        text_beat_t bt;
        bt = '{data_byte: b, has_byte: has, end_of_text: eot};
        beat_q.insert(beat_q.size(), bt);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    task automatic add_cp(input logic [CpW-1:0] cp, input int len);
        case (len)
            1: put_byte({1'b0, cp[6:0]});
            2:
            begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({2'b10, cp[17:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // one code point worth of bytes, good or broken in one of many ways
    task automatic add_piece(input bit clean);
        int             pick;
        int             len;
        int             floor_cp;
        int             pos;
        logic [CpW-1:0] cp;
        pick = clean ? $urandom_range(67) : $urandom_range(99);
        len  = 1;
        cp   = 21'h41;
        if (pick < 40)
        begin
            cp = CpW'($urandom_range(8'h20, 8'h7e));
        end
        else if (pick < 50)
        begin
            len = 2;
            cp  = CpW'($urandom_range(12'h0a0, 12'h7ff));
        end
        else if (pick < 60)
        begin
            len = 3;
            cp  = CpW'($urandom_range(16'h0800, 16'hffff));
        end
        else if (pick < 68)
        begin
            len = 4;
            cp  = CpW'($urandom_range(21'h010000, 21'h10ffff));
        end
        else if (pick < 72)
        begin
            cp = ($urandom_range(3) == 0) ? CP_DEL : CpW'($urandom_range(5'h1f));
        end
        else if (pick < 75)
        begin
            len = 2;
            cp  = CpW'($urandom_range(8'h80, 8'ha0));
        end
        else if (pick < 78)
        begin
            // around both bidi ranges, edges included
            len = 3;
            cp  = $urandom_range(1) ? CpW'($urandom_range(16'h2028, 16'h2030))
                                    : CpW'($urandom_range(16'h2064, 16'h206b));
        end
        else if (pick < 80)
        begin
            len = 3;
            cp  = CpW'($urandom_range(16'hd7fe, 16'he001));
        end
        else if (pick < 83)
        begin
            // overlong forms, mostly hugging the minimum for the width
            len      = $urandom_range(2, 4);
            floor_cp = (len == 2) ? 'h80 : (len == 3) ? 'h800 : 'h10000;
            cp       = $urandom_range(1) ? CpW'(floor_cp - int'($urandom_range(2)))
                                         : CpW'($urandom_range(floor_cp - 1));
        end
        else if (pick < 85)
        begin
            len = 4;
            cp  = $urandom_range(1) ? CpW'($urandom_range(21'h10fffe, 21'h110001))
                                    : CpW'($urandom_range(21'h110000, 21'h1fffff));
        end
        else if (pick < 88)
        begin
            put_byte(8'($urandom_range(255)));
            return;
        end
        else if (pick < 91)
        begin
            // sequence cut short
            len = $urandom_range(2, 4);
            add_cp(CpW'($urandom), len);
            repeat ($urandom_range(1, len - 1)) text_buf.delete(text_buf.size() - 1);
            return;
        end
        else if (pick < 94)
        begin
            // one continuation byte replaced by something that is not one
            len = $urandom_range(2, 4);
            add_cp(CpW'($urandom), len);
            pos = text_buf.size() - $urandom_range(1, len - 1);
            case ($urandom_range(2))
                0:       text_buf[pos] = {2'b00, 6'($urandom)};
                1:       text_buf[pos] = {2'b01, 6'($urandom)};
                default: text_buf[pos] = {2'b11, 6'($urandom)};
            endcase
            return;
        end
        else
        begin
            case ($urandom_range(7))
                0:
                begin
                    len = 1;
                    cp  = 21'h7e;
                end
                1:
                begin
                    len = 2;
                    cp  = 21'h7ff;
                end
                2:
                begin
                    len = 3;
                    cp  = 21'h800;
                end
                3:
                begin
                    len = 3;
                    cp  = 21'hffff;
                end
                4:
                begin
                    len = 4;
                    cp  = 21'h10000;
                end
                5:
                begin
                    len = 4;
                    cp  = 21'h10ffff;
                end
                6:
                begin
                    len = 2;
                    cp  = 21'ha0;
                end
                default:
                begin
                    len = 2;
                    cp  = 21'h9f;
                end
            endcase
        end
        add_cp(cp, len);
    endtask

    task automatic queue_text(output int n_items);
        bit clean;
        bit split_close;
        int n_pieces;
        text_buf.delete();
        n_items     = 0;
        clean       = ($urandom_range(99) < 55);
        split_close = ($urandom_range(99) < 10);
        n_pieces    = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 8);
        repeat (n_pieces) add_piece(clean);
        for (int i = 0; i < text_buf.size(); i++)
        begin
            if ($urandom_range(99) < 5)
            begin
                push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                n_items++;
            end
            push_beat(text_buf[i], 1'b1, (i == text_buf.size() - 1) && !split_close);
            n_items++;
        end
        // empty texts and some others close on a beat that carries no byte
        if (text_buf.size() == 0 || split_close)
        begin
            push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
            n_items++;
        end
    endtask

    task automatic queue_directed();
        push_beat(8'h00, 1'b0, 1'b1);                       // empty text
        push_beat(8'h20, 1'b1, 1'b0);                       // lowest printable
        push_beat(8'h7e, 1'b1, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);                       // nul, then bytes ignored
        push_beat(8'hff, 1'b1, 1'b0);
        push_beat(8'hff, 1'b0, 1'b1);
        push_beat(8'hc2, 1'b1, 1'b0);                       // u+0080, a c1 control
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'hc0, 1'b1, 1'b0);                       // overlong nul
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'hed, 1'b1, 1'b0);                       // surrogate u+d800
        push_beat(8'ha0, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'hf4, 1'b1, 1'b0);                       // u+110000
        push_beat(8'h90, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'hf0, 1'b1, 1'b0);                       // u+1f600, gap mid sequence
        push_beat(8'h9f, 1'b1, 1'b0);
        push_beat(8'h55, 1'b0, 1'b0);
        push_beat(8'h98, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b1);
        push_beat(8'he2, 1'b1, 1'b0);                       // cut off by the end
        push_beat(8'h80, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    int send_tbl[4]  = '{0, 86, 0, 37};
    int stall_tbl[4] = '{0, 0, 86, 37};

    initial
    begin
        int added;
        int n;
        bytes_if.valid       = 1'b0;
        bytes_if.data_byte   = 8'h00;
        bytes_if.has_byte    = 1'b0;
        bytes_if.end_of_text = 1'b0;
        verdict_if.ready     = 1'b0;
        clear_text_state();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        while (beat_q.size() != 0) @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_tbl[ph];
            stall_pct     = stall_tbl[ph];
            added = 0;
            while (added < 285)
            begin
                queue_text(n);
                added += n;
            end
            while (beat_q.size() != 0) @(posedge clk);
        end

        while (beat_q.size() != 0 || bytes_if.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d byte beats over %0d texts, idle/stall mixes 0/0 86/0 0/86 37/37",
                 beats_taken, texts_closed);
        $display("%0d verdicts checked, %0d passing, %0d mismatches",
                 verdicts_seen, verdicts_ok, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("utf8_safe_text_checker_tb: done, clean");
        else
            $display("utf8_safe_text_checker_tb: done, errors");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d verdicts outstanding", verdict_q.size());
        $display("utf8_safe_text_checker_tb: done, errors");
        $finish;
    end

endmodule
